/* hdl/vsa_pkg.sv */
`default_nettype none

package vsa_pkg;

	// voice table geometry
	localparam int VOICE_SLOTS = 32;
	localparam int IDX_W       = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int CNT_W       = IDX_W + 1;

	// field widths fixed by the interface
	localparam int MODE_W = 2;
	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int SLOT_W = 5;

	// event codes
	localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DONE     = 2'd2;

	// result action codes
	localparam logic ACT_RELEASE = 1'b0;
	localparam logic ACT_START   = 1'b1;

	// one slot of the voice table
	typedef struct packed {
		logic              busy;
		logic              releasing;
		logic [NOTE_W-1:0] note;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hdl/vsa_ram.sv */
`default_nettype none

module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire               clk,
	input  wire               we,
	input  wire  [ADDR_W-1:0] waddr,
	input  wire  [WIDTH-1:0]  wdata,
	input  wire  [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/voice_slot_allocator.sv */
`default_nettype none

// voice slot allocator: takes one note event per transaction (start high while busy
// is low) and answers with zero to two result transactions, each shown for exactly
// one cycle while valid is high; the receiver cannot stall, so results must be taken
// as they come. a note-on or note-off sweeps the whole voice table held in one
// synchronous ram, one slot per cycle, set by the single registered read port: a
// note-on with nonzero velocity keeps busy high through the sweep and a last state
// that writes the new voice, a note-off through the sweep alone. a release result
// shows up the cycle after its slot comes back from the ram, and the start result
// of a note-on in the same cycle that busy drops. a voice-finished event or an
// unused mode is handled in the accept cycle and never raises busy. the table
// comes out of reset empty: per-slot valid flops make never-written slots read as
// free, so no clearing pass is needed.
module voice_slot_allocator (
	input  wire                             clk,
	input  wire                             arst_n,
	// event transaction
	input  wire                             start,
	output logic                            busy,
	input  wire  [vsa_pkg::MODE_W-1:0]      mode,
	input  wire  [vsa_pkg::NOTE_W-1:0]      note,
	input  wire  [vsa_pkg::VEL_W-1:0]       velocity,
	input  wire  [vsa_pkg::SLOT_W-1:0]      done_slot,
	// result transaction
	output logic                            valid,
	output logic                            action,
	output logic [vsa_pkg::SLOT_W-1:0]      slot,
	output logic [vsa_pkg::NOTE_W-1:0]      out_note,
	output logic [vsa_pkg::VEL_W-1:0]       out_velocity,
	output logic                            stolen,
	output logic                            last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_START = 2'd2;

	localparam int IDX_W = vsa_pkg::IDX_W;
	localparam int CNT_W = vsa_pkg::CNT_W;

	logic [1:0] state_q;

	// latched event
	logic                      ev_on_q;   // note-on with nonzero velocity
	logic [vsa_pkg::NOTE_W-1:0] ev_note_q;
	logic [vsa_pkg::VEL_W-1:0]  ev_vel_q;

	// sweep bookkeeping
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             matched_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             rel_found_q;
	logic [IDX_W-1:0] rel_idx_q;

	// slots ever written since reset; others read as the empty entry
	logic [vsa_pkg::VOICE_SLOTS-1:0] written_q;

	// ram ports
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	vsa_pkg::entry_t             ram_wdata;
	logic [IDX_W-1:0]            ram_raddr;
	logic [vsa_pkg::ENTRY_W-1:0] ram_rdata;

	vsa_ram #(
		.WIDTH(vsa_pkg::ENTRY_W),
		.DEPTH(vsa_pkg::VOICE_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic accept;
	logic is_done_ev;
	logic is_note_ev;
	logic issue;
	logic sweep_end;
	logic [IDX_W-1:0] pick;
	vsa_pkg::entry_t  cur;
	logic match;
	logic take_match;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign is_done_ev = (mode == vsa_pkg::MODE_DONE) && (int'(done_slot) < vsa_pkg::VOICE_SLOTS);
	assign is_note_ev = (mode == vsa_pkg::MODE_NOTE_ON) || (mode == vsa_pkg::MODE_NOTE_OFF);

	// read issue side of the sweep
	assign issue     = (state_q == ST_SCAN) && (int'(rd_cnt_q) < vsa_pkg::VOICE_SLOTS);
	assign ram_raddr = rd_cnt_q[IDX_W-1:0];

	// entry coming back from the ram, empty if never written
	always_comb begin
		cur = ram_rdata;
		if (!written_q[idx_s1]) begin
			cur = '0;
		end
	end

	assign match      = rd_s1 && cur.busy && !cur.releasing && (cur.note == ev_note_q);
	// note-on releases every match, note-off only the first one
	assign take_match = match && (ev_on_q || !matched_q);
	assign sweep_end  = rd_s1 && (int'(idx_s1) == vsa_pkg::VOICE_SLOTS - 1);

	// slot for the new voice: lowest free, else lowest releasing, else slot 0
	always_comb begin
		priority if (free_found_q) begin
			pick = free_idx_q;
		end else if (rel_found_q) begin
			pick = rel_idx_q;
		end else begin
			pick = '0;
		end
	end

	// ram write: voice finished at accept, release during sweep, start at the end.
	// a release writes back the entry just read, so reads and writes never collide
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = cur;
		priority if (accept && is_done_ev) begin
			ram_we    = 1'b1;
			ram_waddr = IDX_W'(done_slot);
			ram_wdata = '0;
		end else if (state_q == ST_SCAN && take_match) begin
			ram_we              = 1'b1;
			ram_wdata.releasing = 1'b1;
		end else if (state_q == ST_START) begin
			ram_we              = 1'b1;
			ram_waddr           = pick;
			ram_wdata.busy      = 1'b1;
			ram_wdata.releasing = 1'b0;
			ram_wdata.note      = ev_note_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			rd_s1        <= 1'b0;
			matched_q    <= 1'b0;
			free_found_q <= 1'b0;
			rel_found_q  <= 1'b0;
			written_q    <= '0;
			valid        <= 1'b0;
		end else begin
			// first release result of the event, or the start result
			valid <= ((state_q == ST_SCAN) && match && !matched_q) || (state_q == ST_START);
			rd_s1 <= issue;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_note_ev) begin
						state_q      <= ST_SCAN;
						rd_cnt_q     <= '0;
						matched_q    <= 1'b0;
						free_found_q <= 1'b0;
						rel_found_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (match) begin
						matched_q <= 1'b1;
					end
					if (rd_s1 && !cur.busy && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					// releasing as seen after this event's own releases
					if (rd_s1 && (cur.releasing || match) && !rel_found_q) begin
						rel_found_q <= 1'b1;
					end
					if (sweep_end) begin
						state_q <= ev_on_q ? ST_START : ST_IDLE;
					end
				end
				ST_START: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= ram_raddr;
		if (accept) begin
			ev_on_q   <= (mode == vsa_pkg::MODE_NOTE_ON) && (velocity != '0);
			ev_note_q <= note;
			ev_vel_q  <= velocity;
		end
		if (state_q == ST_SCAN) begin
			if (rd_s1 && !cur.busy && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (rd_s1 && (cur.releasing || match) && !rel_found_q) begin
				rel_idx_q <= idx_s1;
			end
			if (match && !matched_q) begin
				action       <= vsa_pkg::ACT_RELEASE;
				slot         <= vsa_pkg::SLOT_W'(idx_s1);
				out_note     <= ev_note_q;
				out_velocity <= '0;
				stolen       <= 1'b0;
				last         <= !ev_on_q;
			end
		end else if (state_q == ST_START) begin
			action       <= vsa_pkg::ACT_START;
			slot         <= vsa_pkg::SLOT_W'(pick);
			out_note     <= ev_note_q;
			out_velocity <= ev_vel_q;
			// a free slot was not busy; releasing slots and slot 0 fallback are
			stolen       <= !free_found_q;
			last         <= 1'b1;
		end
	end

endmodule

`default_nettype wire

/* dv/voice_slot_checker.sv */
`timescale 1ns / 100ps

module voice_slot_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire                        busy,
	input  wire  [vsa_pkg::MODE_W-1:0] mode,
	input  wire  [vsa_pkg::NOTE_W-1:0] note,
	input  wire  [vsa_pkg::VEL_W-1:0]  velocity,
	input  wire  [vsa_pkg::SLOT_W-1:0] done_slot,
	input  wire                        valid,
	input  wire                        action,
	input  wire  [vsa_pkg::SLOT_W-1:0] slot,
	input  wire  [vsa_pkg::NOTE_W-1:0] out_note,
	input  wire  [vsa_pkg::VEL_W-1:0]  out_velocity,
	input  wire                        stolen,
	input  wire                        last,
	input  wire                        drain_done,
	output int                         pending,
	output int                         fails
);

	typedef struct packed {
		logic                       action;
		logic [vsa_pkg::SLOT_W-1:0] slot;
		logic [vsa_pkg::NOTE_W-1:0] note;
		logic [vsa_pkg::VEL_W-1:0]  vel;
		logic                       stolen;
		logic                       last;
	} voice_result_t;

	// shadow voice table
	logic                       voice_busy [vsa_pkg::VOICE_SLOTS];
	logic [vsa_pkg::NOTE_W-1:0] voice_note [vsa_pkg::VOICE_SLOTS];
	logic                       voice_rel  [vsa_pkg::VOICE_SLOTS];

	voice_result_t expected_results [$];
	bit            leftovers_checked;

	task automatic report_mismatch(input string what);
		fails++;
		$display("[%0t] voice checker: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic voice_result_t make_result(input logic act, input int idx,
		input logic [vsa_pkg::NOTE_W-1:0] n, input logic [vsa_pkg::VEL_W-1:0] v,
		input logic stl, input logic lst);
		voice_result_t r;
		r.action = act;
		r.slot   = vsa_pkg::SLOT_W'(idx);
		r.note   = n;
		r.vel    = v;
		r.stolen = stl;
		r.last   = lst;
		return r;
	endfunction

	// advance the shadow table by one event and queue the results it causes
	task automatic predict_voice_event(input logic [vsa_pkg::MODE_W-1:0] m,
		input logic [vsa_pkg::NOTE_W-1:0] n, input logic [vsa_pkg::VEL_W-1:0] v,
		input logic [vsa_pkg::SLOT_W-1:0] d);
		int  pick;
		bit  found;
		bit  released;
		case (m)
			vsa_pkg::MODE_DONE: begin
				if (int'(d) < vsa_pkg::VOICE_SLOTS) begin
					voice_busy[d] = 1'b0;
					voice_note[d] = '0;
					voice_rel[d]  = 1'b0;
				end
			end
			vsa_pkg::MODE_NOTE_ON, vsa_pkg::MODE_NOTE_OFF: begin
				if (m == vsa_pkg::MODE_NOTE_ON && v != '0) begin
					released = 1'b0;
					for (int i = 0; i < vsa_pkg::VOICE_SLOTS; i++) begin
						if (voice_busy[i] && voice_note[i] == n && !voice_rel[i]) begin
							voice_rel[i] = 1'b1;
							if (!released)
								expected_results.push_back(make_result(
									vsa_pkg::ACT_RELEASE, i, n, '0, 1'b0, 1'b0));
							released = 1'b1;
						end
					end
					found = 1'b0;
					pick  = 0;
					for (int i = 0; i < vsa_pkg::VOICE_SLOTS; i++) begin
						if (!found && !voice_busy[i]) begin
							pick  = i;
							found = 1'b1;
						end
					end
					for (int i = 0; i < vsa_pkg::VOICE_SLOTS; i++) begin
						if (!found && voice_rel[i]) begin
							pick  = i;
							found = 1'b1;
						end
					end
					expected_results.push_back(make_result(
						vsa_pkg::ACT_START, pick, n, v, voice_busy[pick], 1'b1));
					voice_busy[pick] = 1'b1;
					voice_note[pick] = n;
					voice_rel[pick]  = 1'b0;
				end else begin
					found = 1'b0;
					for (int i = 0; i < vsa_pkg::VOICE_SLOTS; i++) begin
						if (!found && voice_busy[i] && voice_note[i] == n && !voice_rel[i]) begin
							voice_rel[i] = 1'b1;
							expected_results.push_back(make_result(
								vsa_pkg::ACT_RELEASE, i, n, '0, 1'b0, 1'b1));
							found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		voice_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < vsa_pkg::VOICE_SLOTS; i++) begin
				voice_busy[i] = 1'b0;
				voice_note[i] = '0;
				voice_rel[i]  = 1'b0;
			end
			expected_results.delete();
			leftovers_checked = 1'b0;
			pending = 0;
		end else begin
			// results first: they always belong to events taken earlier
			if (valid === 1'b1) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result act %0d slot %0d note %0d vel %0d",
						action, slot, out_note, out_velocity));
				end else begin
					want = expected_results.pop_front();
					check_field("action", 32'(action), 32'(want.action));
					check_field("slot", 32'(slot), 32'(want.slot));
					check_field("out_note", 32'(out_note), 32'(want.note));
					check_field("out_velocity", 32'(out_velocity), 32'(want.vel));
					check_field("stolen", 32'(stolen), 32'(want.stolen));
					check_field("last", 32'(last), 32'(want.last));
				end
			end
			if (start && !busy)
				predict_voice_event(mode, note, velocity, done_slot);
			if (drain_done && !leftovers_checked) begin
				if (expected_results.size() != 0)
					report_mismatch($sformatf("%0d results never arrived",
						expected_results.size()));
				leftovers_checked = 1'b1;
			end
			pending = expected_results.size();
		end
	end

endmodule

/* dv/tb_voice_slot_allocator.sv */
`timescale 1ns / 100ps

module tb_voice_slot_allocator;

	// the one mode code the block leaves unused
	localparam logic [vsa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	// covers the slowest run of 1900 events, each a sweep plus the longest gap, with margin
	localparam int CYCLE_LIMIT   = 800000;
	// wait well past the length of a sweep at the end
	localparam int TAIL_CYCLES   = 80;
	localparam int RANDOM_EVENTS = 1900;

	// traffic mixes: fill the table (steals), balanced, drain it
	typedef enum int {EP_FILL, EP_MIX, EP_DRAIN} episode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [vsa_pkg::MODE_W-1:0] mode;
	logic [vsa_pkg::NOTE_W-1:0] note;
	logic [vsa_pkg::VEL_W-1:0]  velocity;
	logic [vsa_pkg::SLOT_W-1:0] done_slot;
	logic                       valid;
	logic                       action;
	logic [vsa_pkg::SLOT_W-1:0] slot;
	logic [vsa_pkg::NOTE_W-1:0] out_note;
	logic [vsa_pkg::VEL_W-1:0]  out_velocity;
	logic                       stolen;
	logic                       last;
	logic                       drain_done;
	int                         pending;
	int                         fails;
	int                         cycle_count;

	// small set of notes per episode so note-offs and repeats find matches
	logic [vsa_pkg::NOTE_W-1:0] note_pool [8];

	voice_slot_allocator uut (.*);

	voice_slot_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.note         (note),
		.velocity     (velocity),
		.done_slot    (done_slot),
		.valid        (valid),
		.action       (action),
		.slot         (slot),
		.out_note     (out_note),
		.out_velocity (out_velocity),
		.stolen       (stolen),
		.last         (last),
		.drain_done   (drain_done),
		.pending      (pending),
		.fails        (fails)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hang or a lost result ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("voice_slot_allocator verification failed");
		$finish;
	end

	// present one event at the falling edge and hold it until a rising edge takes it
	task automatic send_event(input logic [vsa_pkg::MODE_W-1:0] m,
		input logic [vsa_pkg::NOTE_W-1:0] n, input logic [vsa_pkg::VEL_W-1:0] v,
		input logic [vsa_pkg::SLOT_W-1:0] d);
		@(negedge clk);
		start     <= 1'b1;
		mode      <= m;
		note      <= n;
		velocity  <= v;
		done_slot <= d;
		@(posedge clk);
		// busy read here is the value the edge saw
		while (busy) @(posedge clk);
	endtask

	// drop start, with junk on the fields; an n of zero does nothing
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start     <= 1'b0;
			mode      <= vsa_pkg::MODE_W'($urandom);
			note      <= vsa_pkg::NOTE_W'($urandom);
			velocity  <= vsa_pkg::VEL_W'($urandom);
			done_slot <= vsa_pkg::SLOT_W'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic random_event(input episode_t kind, output logic [vsa_pkg::MODE_W-1:0] m,
		output logic [vsa_pkg::NOTE_W-1:0] n, output logic [vsa_pkg::VEL_W-1:0] v,
		output logic [vsa_pkg::SLOT_W-1:0] d);
		int r;
		int on_pct;
		int off_pct;
		int done_pct;
		case (kind)
			EP_FILL: begin
				on_pct = 75; off_pct = 10; done_pct = 12;
			end
			EP_MIX: begin
				on_pct = 45; off_pct = 30; done_pct = 22;
			end
			default: begin
				on_pct = 15; off_pct = 35; done_pct = 47;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < on_pct)
			m = vsa_pkg::MODE_NOTE_ON;
		else if (r < on_pct + off_pct)
			m = vsa_pkg::MODE_NOTE_OFF;
		else if (r < on_pct + off_pct + done_pct)
			m = vsa_pkg::MODE_DONE;
		else
			m = MODE_UNUSED;
		n = ($urandom_range(0, 3) != 0) ? note_pool[$urandom_range(0, 7)]
			: vsa_pkg::NOTE_W'($urandom);
		// zero velocity turns a note-on into a note-off
		r = $urandom_range(0, 99);
		if (r < 8)
			v = '0;
		else if (r < 13)
			v = '1;
		else if (r < 18)
			v = vsa_pkg::VEL_W'(1);
		else
			v = vsa_pkg::VEL_W'($urandom_range(1, 127));
		d = vsa_pkg::SLOT_W'($urandom);
	endtask

	initial begin
		logic [vsa_pkg::MODE_W-1:0] m;
		logic [vsa_pkg::NOTE_W-1:0] n;
		logic [vsa_pkg::VEL_W-1:0]  v;
		logic [vsa_pkg::SLOT_W-1:0] d;
		episode_t                   kind;
		int                         ep_len;
		int                         real_events;
		bit                         no_gaps;
		bit                         first_pause;

		start      = 1'b0;
		mode       = '0;
		note       = '0;
		velocity   = '0;
		done_slot  = '0;
		drain_done = 1'b0;
		arst_n     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, lowest note / velocity, zero-velocity off,
		// release plus start, note held in a releasing slot, finished voices
		send_event(vsa_pkg::MODE_NOTE_OFF, '0, '0, '0);                 // nothing to release
		send_event(vsa_pkg::MODE_NOTE_ON, '0, '0, '0);                  // zero velocity
		send_event(vsa_pkg::MODE_NOTE_ON, '0, '1, '0);                  // lowest free slot
		send_event(vsa_pkg::MODE_NOTE_ON, '1, vsa_pkg::VEL_W'(1), '1);  // highest note
		send_event(vsa_pkg::MODE_NOTE_ON, '0, vsa_pkg::VEL_W'(64), '0); // release then start
		send_event(vsa_pkg::MODE_NOTE_ON, '0, '0, '1);                  // zero velocity off
		idle_cycles(3);
		send_event(vsa_pkg::MODE_NOTE_OFF, '1, '1, '0);                 // plain note-off
		send_event(vsa_pkg::MODE_NOTE_OFF, '1, '0, '1);                 // already releasing
		send_event(vsa_pkg::MODE_NOTE_ON, '1, vsa_pkg::VEL_W'(100), '0); // note sits releasing
		send_event(vsa_pkg::MODE_DONE, '1, '1, vsa_pkg::SLOT_W'(1));    // free a busy slot
		send_event(vsa_pkg::MODE_NOTE_ON, vsa_pkg::NOTE_W'(45), '1, '0); // reuse freed slot
		send_event(vsa_pkg::MODE_DONE, '0, '0, '1);                     // top slot, never used
		send_event(vsa_pkg::MODE_DONE, '0, '0, '0);
		send_event(MODE_UNUSED, '1, '1, '1);                            // ignored
		send_event(MODE_UNUSED, '0, '0, '0);
		send_event(vsa_pkg::MODE_NOTE_ON, '1, '1, '1);                  // retrigger top note
		send_event(vsa_pkg::MODE_NOTE_OFF, vsa_pkg::NOTE_W'(45), '0, '0);
		idle_cycles(gap_len());
		send_event(vsa_pkg::MODE_DONE, '0, '0, vsa_pkg::SLOT_W'(2));
		send_event(vsa_pkg::MODE_DONE, '0, '0, vsa_pkg::SLOT_W'(3));
		send_event(vsa_pkg::MODE_NOTE_ON, vsa_pkg::NOTE_W'(85), vsa_pkg::VEL_W'(42),
			vsa_pkg::SLOT_W'(21));

		// random episodes
		real_events = 0;
		first_pause = 1'b1;
		while (real_events < RANDOM_EVENTS) begin
			kind    = episode_t'($urandom_range(0, 2));
			ep_len  = $urandom_range(40, 150);
			no_gaps = ($urandom_range(0, 3) == 0);
			foreach (note_pool[j])
				note_pool[j] = vsa_pkg::NOTE_W'($urandom);
			for (int j = 0; j < ep_len && real_events < RANDOM_EVENTS; j++) begin
				random_event(kind, m, n, v, d);
				send_event(m, n, v, d);
				// ignored events do not count toward the total
				if (m != MODE_UNUSED)
					real_events++;
				if (!no_gaps)
					idle_cycles(gap_len());
			end
			// hold off now and then until every expected result is back
			if (first_pause || $urandom_range(0, 2) == 0) begin
				idle_cycles(1);
				while (pending != 0) @(negedge clk);
				first_pause = 1'b0;
			end
		end

		// drain: everything back, then let a last sweep finish
		idle_cycles(1);
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		drain_done <= 1'b1;
		repeat (2) @(negedge clk);

		if (fails == 0)
			$display("voice_slot_allocator verification clean");
		else
			$display("voice_slot_allocator verification failed");
		$finish;
	end

endmodule
